FILE: rtl/dual_serial_controller_regs_core_defines.svh
// Assertion macros used by the RTL core of the dual serial controller.
`ifndef DUAL_SERIAL_CONTROLLER_REGS_CORE_DEFINES_SVH
`define DUAL_SERIAL_CONTROLLER_REGS_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define DSCR_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
`define DSCR_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define DSCR_ASSERT_ALWAYS(label, clk, rst, cond, msg)
`define DSCR_ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`endif

`endif

FILE: rtl/dscr_pkg.sv
package dscr_pkg;

  localparam int FIFO_DEPTH_DEFAULT = 3;

  localparam logic [2:0] ACT_READ  = 3'd0;
  localparam logic [2:0] ACT_WRITE = 3'd1;
  localparam logic [2:0] ACT_RX    = 3'd2;
  localparam logic [2:0] ACT_TICK  = 3'd3;
  localparam logic [2:0] ACT_RETI  = 3'd4;
  localparam logic [2:0] ACT_POLL  = 3'd5;

  localparam logic [2:0] CAUSE_TX  = 3'b001;
  localparam logic [2:0] CAUSE_RX  = 3'b010;
  localparam logic [2:0] CAUSE_ERR = 3'b100;
  localparam logic [2:0] CAUSE_ALL = 3'b111;

  localparam logic [2:0] PTR_R0 = 3'd0;
  localparam logic [2:0] PTR_R1 = 3'd1;
  localparam logic [2:0] PTR_R2 = 3'd2;

  localparam logic [2:0] CMD_RESET_ERR_INT = 3'd2;
  localparam logic [2:0] CMD_CHAN_RESET    = 3'd3;
  localparam logic [2:0] CMD_RESET_TX_INT  = 3'd5;
  localparam logic [2:0] CMD_ERROR_RESET   = 3'd6;
  localparam logic [2:0] CMD_RETI          = 3'd7;

  localparam logic [7:0] RR0_RESET        = 8'h2C;
  localparam logic [7:0] RR1_RESET        = 8'h01;
  localparam logic [7:0] READ_UNSUPPORTED = 8'hFF;
  localparam logic [7:0] STATUS_KEEP      = 8'h3F;
  localparam logic [7:0] ERR_INT_KEEP     = 8'hCF;
  localparam logic [7:0] ERROR_KEEP       = 8'h8F;
  localparam logic [7:0] OVERRUN_BIT      = 8'h20;
  localparam logic [7:0] RX_MODE_MASK     = 8'h18;
  localparam logic [7:0] RX_INT_FIRST     = 8'h08;
  localparam logic [7:0] RX_INT_ALL_PAR   = 8'h10;
  localparam logic [7:0] RX_INT_ALL       = 8'h18;
  localparam logic [7:0] VEC_KEEP         = 8'hF1;
  localparam logic [7:0] VEC_CH_A         = 8'h08;
  localparam logic [7:0] VEC_RX           = 8'h04;
  localparam logic [7:0] VEC_ERR          = 8'h02;

  typedef struct packed {
    logic [7:0][7:0] wr;
    logic [7:0]      rr0;
    logic [7:0]      rr1;
    logic [7:0]      rr2;
    logic [2:0]      cause;
    logic            irq;
  } chan_t;

  typedef chan_t [1:0] chan_pair_t;

  localparam chan_t CHAN_RESET = '{
    wr:    '0,
    rr0:   RR0_RESET,
    rr1:   RR1_RESET,
    rr2:   8'h00,
    cause: 3'b000,
    irq:   1'b0
  };

  typedef struct packed {
    logic [2:0] action;
    logic       channel_b;
    logic       data_port;
    logic [7:0] write_data;
    logic [7:0] rx_byte;
    logic       host_tx_ready;
  } item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       rx_dropped;
    logic       irq_valid;
    logic [7:0] irq_vector;
    logic       irq_from_b;
  } result_t;

endpackage

FILE: rtl/dscr_step.sv
module dscr_step #(
  parameter int FIFO_DEPTH = dscr_pkg::FIFO_DEPTH_DEFAULT
) (
  input  dscr_pkg::item_t    item,
  input  dscr_pkg::chan_pair_t chan_q,
  input  logic [7:0]         fifo_q [2][FIFO_DEPTH],
  input  logic [$clog2(FIFO_DEPTH + 1)-1:0] cnt_q [2],
  output dscr_pkg::chan_pair_t chan_next,
  output logic [7:0]         fifo_next [2][FIFO_DEPTH],
  output logic [$clog2(FIFO_DEPTH + 1)-1:0] cnt_next [2],
  output dscr_pkg::result_t  res_next
);

  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
  localparam int IDX_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(FIFO_DEPTH);
  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

  function automatic dscr_pkg::chan_pair_t drop_cause(dscr_pkg::chan_pair_t s, logic c,
                                                     logic [2:0] m);
    s[c].cause = s[c].cause & ~m;
    if ((s[0].cause | s[1].cause) == 3'b000) begin
      s[0].rr1[1] = 1'b0;
      s[c].irq = 1'b0;
    end
    return s;
  endfunction

  function automatic dscr_pkg::chan_pair_t raise_cause(dscr_pkg::chan_pair_t s, logic c,
                                                      logic [2:0] m);
    logic [2:0] fresh;
    fresh = ~s[c].cause & m;
    s[c].cause = s[c].cause | m;
    if ((|fresh) && !s[0].irq) begin
      s[c].irq = 1'b1;
      s[0].rr1[1] = 1'b1;
    end
    return s;
  endfunction

  function automatic logic [7:0] vector_for(dscr_pkg::chan_pair_t s, logic c);
    logic [7:0] v;
    v = s[1].wr[2];
    if (s[1].wr[1][2]) begin
      v = v & dscr_pkg::VEC_KEEP;
      if (!c) begin
        v = v | dscr_pkg::VEC_CH_A;
      end
      if (s[c].cause[1]) begin
        v = v | dscr_pkg::VEC_RX;
      end else if (s[c].cause[2]) begin
        v = v | dscr_pkg::VEC_ERR;
      end
    end
    return v;
  endfunction

  logic                 ch;
  logic [2:0]           ptr;
  logic                 sel_b;
  dscr_pkg::chan_pair_t st;

  assign ch = item.channel_b;

  always_comb begin
    st = chan_q;
    fifo_next = fifo_q;
    cnt_next = cnt_q;
    res_next = '0;
    ptr = chan_q[ch].wr[0][2:0];
    sel_b = 1'b0;
    unique case (item.action)
      dscr_pkg::ACT_READ: begin
        if (!item.data_port) begin
          st[ch].wr[0][2:0] = 3'd0;
          st[ch].rr0[1] = !ch && (|(st[0].cause | st[1].cause));
          priority if (ptr == dscr_pkg::PTR_R0) begin
            res_next.read_data = st[ch].rr0;
          end else if (ptr == dscr_pkg::PTR_R1) begin
            res_next.read_data = st[ch].rr1;
          end else if (ptr == dscr_pkg::PTR_R2 && ch) begin
            res_next.read_data = st[ch].rr2;
          end else begin
            res_next.read_data = dscr_pkg::READ_UNSUPPORTED;
          end
        end else begin
          res_next.read_data = fifo_q[ch][0];
          for (int i = 0; i < FIFO_DEPTH - 1; i++) begin
            fifo_next[ch][i] = fifo_q[ch][i + 1];
          end
          if (cnt_next[ch] != '0) begin
            cnt_next[ch] = cnt_next[ch] - CNT_ONE;
          end
          if (cnt_next[ch] == '0) begin
            st[ch].rr0[0] = 1'b0;
          end
          st = drop_cause(st, ch, dscr_pkg::CAUSE_RX);
          st[ch].rr0 = st[ch].rr0 & dscr_pkg::STATUS_KEEP;
          st[ch].rr1 = st[ch].rr1 & dscr_pkg::STATUS_KEEP;
          if (cnt_next[ch] != '0 && st[ch].wr[1][4]) begin
            st = raise_cause(st, ch, dscr_pkg::CAUSE_RX);
          end
        end
      end
      dscr_pkg::ACT_WRITE: begin
        if (item.data_port) begin
          st[ch].rr0[2] = 1'b0;
          st = drop_cause(st, ch, dscr_pkg::CAUSE_TX);
          res_next.tx_valid = 1'b1;
          res_next.tx_byte = item.write_data;
        end else if (ptr != dscr_pkg::PTR_R0) begin
          st[ch].wr[ptr] = item.write_data;
          if (ch && ptr == dscr_pkg::PTR_R2) begin
            st[ch].rr2 = item.write_data;
          end
          st[ch].wr[0][2:0] = 3'd0;
        end else begin
          st[ch].wr[0] = item.write_data;
          unique case (item.write_data[5:3])
            dscr_pkg::CMD_RESET_ERR_INT: begin
              st = drop_cause(st, ch, dscr_pkg::CAUSE_ERR);
              st[ch].rr1 = st[ch].rr1 & dscr_pkg::ERR_INT_KEEP;
            end
            dscr_pkg::CMD_CHAN_RESET: begin
              st[ch].rr0 = dscr_pkg::RR0_RESET;
              st[ch].rr1 = dscr_pkg::RR1_RESET;
              st[ch].rr2 = 8'h00;
              st = drop_cause(st, ch, dscr_pkg::CAUSE_ALL);
            end
            dscr_pkg::CMD_RESET_TX_INT: begin
              st = drop_cause(st, ch, dscr_pkg::CAUSE_TX);
            end
            dscr_pkg::CMD_ERROR_RESET: begin
              st[ch].rr1 = st[ch].rr1 & dscr_pkg::ERROR_KEEP;
            end
            dscr_pkg::CMD_RETI: begin
              if (!ch) begin
                st[0].irq = 1'b0;
                st[0].rr1[1] = 1'b0;
                st = drop_cause(st, 1'b0, dscr_pkg::CAUSE_ALL);
                st = drop_cause(st, 1'b1, dscr_pkg::CAUSE_ALL);
              end
            end
            default: ;
          endcase
        end
      end
      dscr_pkg::ACT_RX: begin
        if (!st[ch].wr[3][0]) begin
          res_next.rx_dropped = 1'b1;
        end else if (cnt_next[ch] >= DEPTH_CNT) begin
          fifo_next[ch][FIFO_DEPTH - 1] = item.rx_byte;
          st[ch].rr1 = st[ch].rr1 | dscr_pkg::OVERRUN_BIT;
          st = raise_cause(st, ch, dscr_pkg::CAUSE_ERR);
        end else begin
          fifo_next[ch][cnt_next[ch][IDX_W-1:0]] = item.rx_byte;
          cnt_next[ch] = cnt_next[ch] + CNT_ONE;
          st[ch].rr0[0] = 1'b1;
          unique case (st[ch].wr[1] & dscr_pkg::RX_MODE_MASK)
            dscr_pkg::RX_INT_FIRST: begin
              if (cnt_next[ch] == CNT_ONE) begin
                st = raise_cause(st, ch, dscr_pkg::CAUSE_RX);
              end
            end
            dscr_pkg::RX_INT_ALL_PAR, dscr_pkg::RX_INT_ALL: begin
              st = raise_cause(st, ch, dscr_pkg::CAUSE_RX);
            end
            default: ;
          endcase
        end
      end
      dscr_pkg::ACT_TICK: begin
        if ((ch || item.host_tx_ready) && !st[ch].rr0[2]) begin
          st[ch].rr0[2] = 1'b1;
          if (st[ch].wr[1][1]) begin
            st = raise_cause(st, ch, dscr_pkg::CAUSE_TX);
          end
        end
      end
      dscr_pkg::ACT_RETI, dscr_pkg::ACT_POLL: begin
        if (item.action == dscr_pkg::ACT_RETI) begin
          st[0].irq = 1'b0;
        end
        sel_b = !st[0].irq;
        if (st[0].irq || st[1].irq) begin
          res_next.irq_valid = 1'b1;
          res_next.irq_vector = vector_for(st, sel_b);
          res_next.irq_from_b = sel_b;
        end
      end
      default: ;
    endcase
    chan_next = st;
  end

endmodule

FILE: rtl/dual_serial_controller_regs_core.sv
// Channel  Handshake            Payload
// in       in_valid / in_ready  action, channel_b, data_port, write_data, rx_byte,
//                               host_tx_ready
// out      out_valid/out_ready  read_data, tx_valid, tx_byte, rx_dropped, irq_valid,
//                               irq_vector, irq_from_b
//
// An accepted transfer is held in the input register until the register update logic
// loads its result into the result register, from which the result is offered.
// One transfer is accepted every cycle while results are taken.
// Reset is synchronous; it clears the handshake, channel state and FIFO counts, not the input
// and result registers or the receive FIFO data, which is to be read only once written (not enforced).
// When out_ready is low, one more transfer is held in the input register before in_ready drops.
`include "dual_serial_controller_regs_core_defines.svh"

module dual_serial_controller_regs_core #(
  parameter int FIFO_DEPTH = dscr_pkg::FIFO_DEPTH_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] action,
  input  logic       channel_b,
  input  logic       data_port,
  input  logic [7:0] write_data,
  input  logic [7:0] rx_byte,
  input  logic       host_tx_ready,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] read_data,
  output logic       tx_valid,
  output logic [7:0] tx_byte,
  output logic       rx_dropped,
  output logic       irq_valid,
  output logic [7:0] irq_vector,
  output logic       irq_from_b
);

  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  dscr_pkg::item_t      item_q;
  logic                 item_valid;
  logic                 advance;
  dscr_pkg::chan_pair_t chan_q;
  dscr_pkg::chan_pair_t chan_next;
  logic [7:0]           fifo_q [2][FIFO_DEPTH];
  logic [7:0]           fifo_next [2][FIFO_DEPTH];
  logic [CNT_W-1:0]     cnt_q [2];
  logic [CNT_W-1:0]     cnt_next [2];
  dscr_pkg::result_t    res_q;
  dscr_pkg::result_t    res_next;

  assign advance = item_valid && (!out_valid || out_ready);
  assign in_ready = !item_valid || advance;

  dscr_step #(
    .FIFO_DEPTH(FIFO_DEPTH)
  ) u_step (
    .item      (item_q),
    .chan_q    (chan_q),
    .fifo_q    (fifo_q),
    .cnt_q     (cnt_q),
    .chan_next (chan_next),
    .fifo_next (fifo_next),
    .cnt_next  (cnt_next),
    .res_next  (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      out_valid <= 1'b0;
      chan_q <= {dscr_pkg::CHAN_RESET, dscr_pkg::CHAN_RESET};
      cnt_q[0] <= '0;
      cnt_q[1] <= '0;
    end else begin
      if (in_ready) begin
        item_valid <= in_valid;
      end
      if (advance) begin
        out_valid <= 1'b1;
        chan_q <= chan_next;
        cnt_q <= cnt_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_q <= '{
        action:        action,
        channel_b:     channel_b,
        data_port:     data_port,
        write_data:    write_data,
        rx_byte:       rx_byte,
        host_tx_ready: host_tx_ready
      };
    end
    if (advance) begin
      res_q <= res_next;
      fifo_q <= fifo_next;
    end
  end

  assign read_data = res_q.read_data;
  assign tx_valid = res_q.tx_valid;
  assign tx_byte = res_q.tx_byte;
  assign rx_dropped = res_q.rx_dropped;
  assign irq_valid = res_q.irq_valid;
  assign irq_vector = res_q.irq_vector;
  assign irq_from_b = res_q.irq_from_b;

  `DSCR_ASSERT_ALWAYS(a_fifo_count_bound, clk, rst, (cnt_q[0] <= CNT_W'(FIFO_DEPTH)) && (cnt_q[1] <= CNT_W'(FIFO_DEPTH)), "receive FIFO count above depth")
  `DSCR_ASSERT_ALWAYS(a_pending_flag, clk, rst, (|(chan_q[0].cause | chan_q[1].cause)) || !chan_q[0].rr1[1], "interrupt pending flag set with no cause")
  `DSCR_ASSERT_IMPLY(a_one_event, clk, rst, out_valid, $onehot0({res_q.tx_valid, res_q.rx_dropped, res_q.irq_valid}), "more than one event flag in a result")
  `DSCR_ASSERT_IMPLY(a_stall_only, clk, rst, !in_ready, item_valid && out_valid && !out_ready, "input stalled without a full pipeline")

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import dscr_pkg::*;

  localparam logic       CH_A        = 1'b0;
  localparam logic       CH_B        = 1'b1;
  localparam logic       PORT_CTRL   = 1'b0;
  localparam logic       PORT_DATA   = 1'b1;
  localparam logic [2:0] ACT_SPARE_6 = 3'd6;
  localparam logic [2:0] ACT_SPARE_7 = 3'd7;
  localparam logic [2:0] CMD_NULL    = 3'd0;
  localparam logic [2:0] PTR_R3      = 3'd3;
  localparam logic [2:0] PTR_R7      = 3'd7;
  localparam int         PHASE_ITEMS = 400;
  localparam int         HOLD_CYCLES = 250;
  localparam int         STALL_LIMIT = 2000;

  class serial_ctrl_tracker;
    localparam int DEPTH = dscr_pkg::FIFO_DEPTH_DEFAULT;

    logic [7:0]  wreg [2][8];
    logic [7:0]  rreg [2][3];
    logic [7:0]  fifo [2][DEPTH];
    bit          written [2][DEPTH];
    int unsigned count [2];
    bit          req [2];
    logic [2:0]  cause [2];
    logic [7:0]  last_vec [2];
    logic [1:0]  live;
    result_t     expected_replies [$];
    int          errors;
    int          requests;
    int          replies;
    int          irqs;
    int          overruns;
    int          drops;

    function new();
      for (int c = 0; c < 2; c++) begin
        for (int i = 0; i < 8; i++) wreg[c][i] = '0;
        for (int i = 0; i < DEPTH; i++) begin
          fifo[c][i] = '0;
          written[c][i] = 1'b0;
        end
        count[c] = 0;
        req[c] = 1'b0;
        cause[c] = '0;
        last_vec[c] = '0;
      end
      live = '0;
      chan_init(0);
      chan_init(1);
    endfunction

    function void clear_cause(int unsigned ch, logic [2:0] m);
      cause[ch] &= ~m;
      if ((cause[0] | cause[1]) == '0) begin
        rreg[0][1][1] = 1'b0;
        req[ch] = 1'b0;
      end
    endfunction

    function void set_cause(int unsigned ch, logic [2:0] m);
      logic [2:0] fresh;
      fresh = ~cause[ch] & m;
      cause[ch] |= m;
      if (fresh != '0 && !req[0]) begin
        req[ch] = 1'b1;
        rreg[0][1][1] = 1'b1;
      end
    endfunction

    function void chan_init(int unsigned ch);
      rreg[ch][0] = RR0_RESET;
      rreg[ch][1] = RR1_RESET;
      rreg[ch][2] = '0;
      clear_cause(ch, CAUSE_ALL);
    endfunction

    function bit deliver(int unsigned ch, inout result_t r);
      logic [7:0] v;
      v = wreg[1][2];
      if (!req[ch]) return 1'b0;
      if (wreg[1][1][2]) begin
        v &= VEC_KEEP;
        if (ch == 0) v |= VEC_CH_A;
        if ((cause[ch] & CAUSE_RX) != '0) v |= VEC_RX;
        else if ((cause[ch] & CAUSE_ERR) != '0) v |= VEC_ERR;
      end
      last_vec[ch] = v;
      live = 2'(ch + 1);
      r.irq_valid = 1'b1;
      r.irq_vector = v;
      r.irq_from_b = 1'(ch);
      irqs++;
      return 1'b1;
    endfunction

    function void poll(inout result_t r);
      if (!deliver(0, r)) void'(deliver(1, r));
    endfunction

    function logic [7:0] bus_read(int unsigned ch, logic data);
      logic [2:0] r;
      logic [7:0] c;
      int i;
      if (!data) begin
        r = wreg[ch][0][2:0];
        wreg[ch][0][2:0] = '0;
        rreg[ch][0][1] = 1'b0;
        if (ch == 0 && (cause[0] | cause[1]) != '0) rreg[ch][0][1] = 1'b1;
        if (r <= PTR_R1) return rreg[ch][r];
        if (r == PTR_R2 && ch == 1) return rreg[ch][2];
        return READ_UNSUPPORTED;
      end
      c = fifo[ch][0];
      for (i = 0; i + 1 < DEPTH; i++) begin
        fifo[ch][i] = fifo[ch][i + 1];
        written[ch][i] = written[ch][i + 1];
      end
      if (count[ch] != 0) count[ch]--;
      if (count[ch] == 0) rreg[ch][0][0] = 1'b0;
      clear_cause(ch, CAUSE_RX);
      rreg[ch][0] &= STATUS_KEEP;
      rreg[ch][1] &= STATUS_KEEP;
      if (count[ch] != 0 && wreg[ch][1][4]) set_cause(ch, CAUSE_RX);
      return c;
    endfunction

    function void control_write(int unsigned ch, logic [7:0] val);
      logic [2:0] r;
      r = wreg[ch][0][2:0];
      if (r != PTR_R0) begin
        wreg[ch][r] = val;
        if (ch == 1 && r == PTR_R2) rreg[ch][2] = val;
        wreg[ch][0][2:0] = '0;
        return;
      end
      wreg[ch][0] = val;
      case (val[5:3])
        CMD_RESET_ERR_INT: begin
          clear_cause(ch, CAUSE_ERR);
          rreg[ch][1] &= ERR_INT_KEEP;
        end
        CMD_CHAN_RESET: chan_init(ch);
        CMD_RESET_TX_INT: clear_cause(ch, CAUSE_TX);
        CMD_ERROR_RESET: rreg[ch][1] &= ERROR_KEEP;
        CMD_RETI: begin
          if (ch == 0) begin
            req[0] = 1'b0;
            rreg[0][1][1] = 1'b0;
            clear_cause(0, CAUSE_ALL);
            clear_cause(1, CAUSE_ALL);
          end
        end
        default: ;
      endcase
    endfunction

    function logic receive(int unsigned ch, logic [7:0] c);
      if (!wreg[ch][3][0]) begin
        drops++;
        return 1'b1;
      end
      if (count[ch] >= DEPTH) begin
        fifo[ch][DEPTH - 1] = c;
        written[ch][DEPTH - 1] = 1'b1;
        rreg[ch][1] |= OVERRUN_BIT;
        set_cause(ch, CAUSE_ERR);
        overruns++;
        return 1'b0;
      end
      fifo[ch][count[ch]] = c;
      written[ch][count[ch]] = 1'b1;
      count[ch]++;
      rreg[ch][0][0] = 1'b1;
      case (wreg[ch][1] & RX_MODE_MASK)
        RX_INT_FIRST: if (count[ch] == 1) set_cause(ch, CAUSE_RX);
        RX_INT_ALL_PAR, RX_INT_ALL: set_cause(ch, CAUSE_RX);
        default: ;
      endcase
      return 1'b0;
    endfunction

    function result_t predict_transfer(item_t it);
      result_t r;
      int unsigned ch;
      r = '0;
      ch = it.channel_b;
      case (it.action)
        ACT_READ: r.read_data = bus_read(ch, it.data_port);
        ACT_WRITE: begin
          if (it.data_port) begin
            rreg[ch][0][2] = 1'b0;
            clear_cause(ch, CAUSE_TX);
            r.tx_valid = 1'b1;
            r.tx_byte = it.write_data;
          end else begin
            control_write(ch, it.write_data);
          end
        end
        ACT_RX: r.rx_dropped = receive(ch, it.rx_byte);
        ACT_TICK: begin
          if ((ch == 1 || it.host_tx_ready) && !rreg[ch][0][2]) begin
            rreg[ch][0][2] = 1'b1;
            if (wreg[ch][1][1]) set_cause(ch, CAUSE_TX);
          end
        end
        ACT_RETI: begin
          req[0] = 1'b0;
          live = '0;
          poll(r);
        end
        ACT_POLL: poll(r);
        default: ;
      endcase
      return r;
    endfunction

    function void note_request(item_t it);
      expected_replies.push_back(predict_transfer(it));
      requests++;
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $display("%0t: %s expected %02h, got %02h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_reply(result_t got);
      result_t want;
      if (expected_replies.size() == 0) begin
        $display("%0t: result %h arrived with none expected", $time, got);
        errors++;
        return;
      end
      want = expected_replies.pop_front();
      replies++;
      compare_field("read_data", want.read_data, got.read_data);
      compare_field("tx_valid", 8'(want.tx_valid), 8'(got.tx_valid));
      compare_field("tx_byte", want.tx_byte, got.tx_byte);
      compare_field("rx_dropped", 8'(want.rx_dropped), 8'(got.rx_dropped));
      compare_field("irq_valid", 8'(want.irq_valid), 8'(got.irq_valid));
      compare_field("irq_vector", want.irq_vector, got.irq_vector);
      compare_field("irq_from_b", 8'(want.irq_from_b), 8'(got.irq_from_b));
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [2:0] action = '0;
  logic       channel_b = 1'b0;
  logic       data_port = 1'b0;
  logic [7:0] write_data = '0;
  logic [7:0] rx_byte = '0;
  logic       host_tx_ready = 1'b0;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] read_data;
  logic       tx_valid;
  logic [7:0] tx_byte;
  logic       rx_dropped;
  logic       irq_valid;
  logic [7:0] irq_vector;
  logic       irq_from_b;

  serial_ctrl_tracker sb = new();
  item_t   plan [$];
  result_t observed;
  int      send_idle_pct = 0;
  int      recv_stall_pct = 0;
  int      hold_req = 0;
  int      hold_left = 0;
  int      quiet_cycles = 0;

  dual_serial_controller_regs_core uut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .action        (action),
    .channel_b     (channel_b),
    .data_port     (data_port),
    .write_data    (write_data),
    .rx_byte       (rx_byte),
    .host_tx_ready (host_tx_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .read_data     (read_data),
    .tx_valid      (tx_valid),
    .tx_byte       (tx_byte),
    .rx_dropped    (rx_dropped),
    .irq_valid     (irq_valid),
    .irq_vector    (irq_vector),
    .irq_from_b    (irq_from_b)
  );

  always #2 clk = ~clk;

  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req != 0) begin
        hold_left = HOLD_CYCLES;
        hold_req = 0;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      observed = {read_data, tx_valid, tx_byte, rx_dropped, irq_valid, irq_vector, irq_from_b};
      sb.check_reply(observed);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic void add(logic [2:0] act, logic ch, logic dp, logic [7:0] wd,
                              logic [7:0] rb, logic rdy);
    plan.push_back(item_t'{act, ch, dp, wd, rb, rdy});
  endfunction

  function automatic void add_any(logic [2:0] act, logic ch, logic dp);
    add(act, ch, dp, 8'($urandom_range(255)), 8'($urandom_range(255)), 1'($urandom_range(1)));
  endfunction

  function automatic void add_reg(logic ch, logic [2:0] ptr, logic [7:0] val);
    add(ACT_WRITE, ch, PORT_CTRL, {2'b00, CMD_NULL, ptr}, 8'($urandom_range(255)), 1'b0);
    add(ACT_WRITE, ch, PORT_CTRL, val, 8'($urandom_range(255)), 1'b1);
  endfunction

  function automatic void add_command(logic ch, logic [2:0] cmd);
    add(ACT_WRITE, ch, PORT_CTRL, {2'b11, cmd, PTR_R0}, 8'h00, 1'b0);
  endfunction

  function automatic void fill_plan();
    int unsigned k;
    int unsigned r;
    logic        ch;
    logic [2:0]  ptr;
    logic [2:0]  cmd;
    logic [7:0]  v;
    k = $urandom_range(99);
    ch = 1'($urandom_range(1));
    if (k < 15) begin
      r = $urandom_range(9);
      ptr = (r < 3) ? PTR_R1 : (r < 5) ? PTR_R2 : (r < 8) ? PTR_R3 : 3'($urandom_range(7));
      if (ptr == PTR_R2 && $urandom_range(4) != 0) ch = CH_B;
      cmd = ($urandom_range(4) == 0) ? 3'($urandom_range(7)) : CMD_NULL;
      v = 8'($urandom_range(255));
      if (ptr == PTR_R3 && $urandom_range(4) != 0) v[0] = 1'b1;
      add(ACT_WRITE, ch, PORT_CTRL, {2'($urandom_range(3)), cmd, ptr},
          8'($urandom_range(255)), 1'($urandom_range(1)));
      add(ACT_WRITE, ch, PORT_CTRL, v, 8'($urandom_range(255)), 1'($urandom_range(1)));
    end else if (k < 22) begin
      add(ACT_WRITE, ch, PORT_CTRL, {2'($urandom_range(3)), 3'($urandom_range(7)), PTR_R0},
          8'($urandom_range(255)), 1'($urandom_range(1)));
    end else if (k < 30) begin
      if ($urandom_range(1) != 0) add_reg(ch, PTR_R0, {2'b00, CMD_NULL, 3'($urandom_range(7))});
      add_any(ACT_READ, ch, PORT_CTRL);
    end else if (k < 48) begin
      repeat ($urandom_range(1, 4)) add_any(ACT_RX, ch, 1'($urandom_range(1)));
    end else if (k < 62) begin
      repeat ($urandom_range(1, 3)) add_any(ACT_READ, ch, PORT_DATA);
    end else if (k < 70) begin
      add_any(ACT_WRITE, ch, PORT_DATA);
    end else if (k < 78) begin
      add_any(ACT_TICK, ch, 1'($urandom_range(1)));
    end else if (k < 88) begin
      add_any(ACT_POLL, ch, 1'($urandom_range(1)));
    end else if (k < 93) begin
      add_any(ACT_RETI, ch, 1'($urandom_range(1)));
    end else begin
      add_any(3'($urandom_range(7)), ch, 1'($urandom_range(1)));
    end
  endfunction

  task automatic send_item(item_t it);
    // A data read of a FIFO slot that was never filled is turned into a control read.
    if (it.action == ACT_READ && it.data_port && !sb.written[it.channel_b][0])
      it.data_port = PORT_CTRL;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    {action, channel_b, data_port, write_data, rx_byte, host_tx_ready} <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    sb.note_request(it);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.expected_replies.size() != 0) @(posedge clk);
  endtask

  initial begin
    int send_pcts [4];
    int recv_pcts [4];
    int phase;
    int n;
    send_pcts = '{0, 59, 0, 27};
    recv_pcts = '{0, 0, 59, 27};
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    add(ACT_READ, CH_A, PORT_CTRL, 8'h00, 8'h00, 1'b0);
    add(ACT_RX, CH_A, PORT_DATA, 8'hFF, 8'hFF, 1'b1);
    add_reg(CH_A, PTR_R3, 8'h01);
    add_reg(CH_B, PTR_R3, 8'hFF);
    add_reg(CH_B, PTR_R2, 8'hFF);
    add_reg(CH_B, PTR_R1, 8'h1E);
    add_reg(CH_A, PTR_R1, 8'h0A);
    add(ACT_RX, CH_A, PORT_CTRL, 8'hFF, 8'h00, 1'b0);
    add(ACT_RX, CH_A, PORT_CTRL, 8'h00, 8'hFF, 1'b1);
    add(ACT_RX, CH_A, PORT_CTRL, 8'h00, 8'h55, 1'b0);
    add(ACT_RX, CH_A, PORT_CTRL, 8'h00, 8'hAA, 1'b0);
    add(ACT_POLL, CH_A, PORT_CTRL, 8'h00, 8'h00, 1'b0);
    add(ACT_READ, CH_A, PORT_DATA, 8'h00, 8'h00, 1'b0);
    add(ACT_RX, CH_B, PORT_CTRL, 8'h00, 8'h80, 1'b0);
    add_reg(CH_B, PTR_R0, {2'b00, CMD_NULL, PTR_R2});
    add(ACT_READ, CH_B, PORT_CTRL, 8'h00, 8'h00, 1'b0);
    add_reg(CH_A, PTR_R0, {2'b00, CMD_NULL, PTR_R7});
    add(ACT_READ, CH_A, PORT_CTRL, 8'h00, 8'h00, 1'b0);
    add(ACT_TICK, CH_A, PORT_CTRL, 8'h00, 8'h00, 1'b0);
    add(ACT_TICK, CH_A, PORT_CTRL, 8'h00, 8'h00, 1'b1);
    add(ACT_WRITE, CH_A, PORT_DATA, 8'hFF, 8'h00, 1'b0);
    add(ACT_RETI, CH_A, PORT_CTRL, 8'h00, 8'h00, 1'b0);
    add_command(CH_A, CMD_RESET_ERR_INT);
    add_command(CH_B, CMD_CHAN_RESET);
    add_command(CH_B, CMD_RETI);
    add_command(CH_A, CMD_RETI);
    add(ACT_SPARE_6, CH_A, PORT_DATA, 8'hFF, 8'hFF, 1'b1);
    add(ACT_SPARE_7, CH_B, PORT_DATA, 8'hFF, 8'hFF, 1'b1);
    while (plan.size() != 0) send_item(plan.pop_front());
    drain();

    add_reg(CH_A, PTR_R3, 8'h01);
    add_reg(CH_B, PTR_R3, 8'h01);
    add_reg(CH_A, PTR_R1, 8'($urandom_range(255)));
    add_reg(CH_B, PTR_R1, 8'($urandom_range(255)) | VEC_RX);
    for (phase = 0; phase < 4; phase++) begin
      send_idle_pct = send_pcts[phase];
      recv_stall_pct = recv_pcts[phase];
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (plan.size() == 0) fill_plan();
        send_item(plan.pop_front());
        if (phase == 0 && n == PHASE_ITEMS / 3) hold_req = 1;
      end
      drain();
    end
    while (plan.size() != 0) send_item(plan.pop_front());
    drain();
    repeat (20) @(posedge clk);

    $display("Sent %0d transfers and checked %0d results across four idle and stall mixes.",
             sb.requests, sb.replies);
    $display("Delivered %0d interrupts; saw %0d overruns and %0d dropped bytes.",
             sb.irqs, sb.overruns, sb.drops);
    if (sb.errors == 0 && sb.expected_replies.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
